FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Concurrent assertion wrappers, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define CHK_ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Checked on every rising edge, including during reset.
`define CHK_ASSERT(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

`endif

FILE: src/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Types and constants for the ordered value list block.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StW      = 2;
  localparam int unsigned PosW     = 5;
  localparam int unsigned InTdataW  = 40;  // 34 bits of fields, zero padded
  localparam int unsigned OutTdataW = 16;  // 12 bits of fields, zero padded

  typedef enum logic [OpW-1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_DELETE   = 2'd2
  } opcode_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CLOSE,
    S_OPEN,
    S_FINISH
  } state_e;

endpackage

FILE: src/olid_store.sv
// ----------------------------------------------------------------------------
// olid_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module olid_store #(
  parameter int unsigned DEPTH = olid_pkg::DepthDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [olid_pkg::ValW-1:0] wdata_i,
  output logic [olid_pkg::ValW-1:0] rdata_o
);

  logic [olid_pkg::ValW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/olid_seq.sv
// ----------------------------------------------------------------------------
// olid_seq
// Sequencer: walks the entry memory one index per cycle through a single
// compare unit and index stepper, for search, gap closing and gap opening.
// ----------------------------------------------------------------------------
module olid_seq #(
  parameter int unsigned DEPTH = olid_pkg::DepthDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [olid_pkg::OpW-1:0]       in_opcode_i,
  input  logic signed [olid_pkg::ValW-1:0] in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [olid_pkg::StW-1:0]       out_status_o,
  output logic [olid_pkg::PosW-1:0]      out_pos_o,
  output logic [olid_pkg::PosW-1:0]      out_len_o,
  output logic                           re_o,
  output logic [AW-1:0]                  raddr_o,
  output logic                           we_o,
  output logic [AW-1:0]                  waddr_o,
  output logic [olid_pkg::ValW-1:0]      wdata_o,
  input  logic [olid_pkg::ValW-1:0]      rdata_i
);

  olid_pkg::state_e          state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             rd_idx_q, rd_idx_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [AW-1:0]             rd_tag_q, rd_tag_d;
  logic [CW-1:0]             pos_q, pos_d;
  olid_pkg::status_e         st_q, st_d;
  logic [olid_pkg::ValW-1:0] val_q;
  logic                      ov_q, ov_d;
  logic [olid_pkg::StW-1:0]  ost_q;
  logic [olid_pkg::PosW-1:0] opos_q, olen_q;

  logic          accept;
  logic          full;
  logic          more;     // unread entries left in the sweep
  logic          match;
  logic [CW-1:0] rd_dec;
  logic          load_out;

  assign accept   = in_valid_i && (state_q == olid_pkg::S_IDLE);
  assign full     = (cnt_q == CW'(DEPTH));
  assign more     = (rd_idx_q < cnt_q);
  assign rd_dec   = rd_idx_q - CW'(1);
  assign match    = rd_vld_q && (rdata_i == val_q);
  assign load_out = (state_q == olid_pkg::S_FINISH) && (!ov_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olid_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode_i == olid_pkg::OP_DELETE) begin
            state_d = olid_pkg::S_SEARCH;
          end else if (in_opcode_i == olid_pkg::OP_INS_HEAD && !full) begin
            state_d = olid_pkg::S_OPEN;
          end else begin
            state_d = olid_pkg::S_FINISH;
          end
        end
      end
      olid_pkg::S_SEARCH: begin
        if (match) begin
          state_d = olid_pkg::S_CLOSE;
        end else if (!rd_vld_q && !more) begin
          state_d = olid_pkg::S_FINISH;
        end
      end
      olid_pkg::S_CLOSE: begin
        if (!rd_vld_q && !more) state_d = olid_pkg::S_FINISH;
      end
      olid_pkg::S_OPEN: begin
        if (!rd_vld_q && rd_idx_q == '0) state_d = olid_pkg::S_FINISH;
      end
      olid_pkg::S_FINISH: begin
        if (load_out) state_d = olid_pkg::S_IDLE;
      end
      default: state_d = olid_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    rd_tag_d = rd_tag_q;
    pos_d    = pos_q;
    st_d     = st_q;
    re_o     = 1'b0;
    raddr_o  = rd_idx_q[AW-1:0];
    we_o     = 1'b0;
    waddr_o  = rd_tag_q;
    wdata_o  = rdata_i;
    ov_d     = ov_q && !out_ready_i;
    unique case (state_q)
      olid_pkg::S_IDLE: begin
        pos_d = '0;
        st_d  = olid_pkg::ST_OK;
        if (accept) begin
          rd_idx_d = '0;
          if (in_opcode_i == olid_pkg::OP_INS_HEAD ||
              in_opcode_i == olid_pkg::OP_INS_TAIL) begin
            if (full) begin
              st_d = olid_pkg::ST_FULL;
            end else if (in_opcode_i == olid_pkg::OP_INS_TAIL) begin
              we_o    = 1'b1;
              waddr_o = cnt_q[AW-1:0];
              wdata_o = in_value_i;
              cnt_d   = cnt_q + CW'(1);
            end else begin
              rd_idx_d = cnt_q;
            end
          end
        end
      end
      olid_pkg::S_SEARCH: begin
        if (match) begin
          pos_d    = CW'(rd_tag_q) + CW'(1);
          rd_idx_d = CW'(rd_tag_q) + CW'(1);
        end else if (more) begin
          re_o     = 1'b1;
          rd_vld_d = 1'b1;
          rd_tag_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          st_d = olid_pkg::ST_NOT_FOUND;
        end
      end
      olid_pkg::S_CLOSE: begin
        // read index k, write its data one place toward the head
        if (rd_vld_q) begin
          we_o    = 1'b1;
          waddr_o = rd_tag_q - AW'(1);
        end
        if (more) begin
          re_o     = 1'b1;
          rd_vld_d = 1'b1;
          rd_tag_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      olid_pkg::S_OPEN: begin
        // walk from the tail down, moving each entry one place back
        if (rd_vld_q) begin
          we_o    = 1'b1;
          waddr_o = rd_tag_q + AW'(1);
        end else if (rd_idx_q == '0) begin
          we_o    = 1'b1;
          waddr_o = '0;
          wdata_o = val_q;
          cnt_d   = cnt_q + CW'(1);
        end
        if (rd_idx_q != '0) begin
          re_o     = 1'b1;
          raddr_o  = rd_dec[AW-1:0];
          rd_vld_d = 1'b1;
          rd_tag_d = rd_dec[AW-1:0];
          rd_idx_d = rd_dec;
        end
      end
      olid_pkg::S_FINISH: begin
        if (load_out) ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= olid_pkg::S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    rd_tag_q <= rd_tag_d;
    pos_q    <= pos_d;
    st_q     <= st_d;
    if (accept) begin
      val_q <= in_value_i;
    end
    if (load_out) begin
      ost_q  <= st_q;
      opos_q <= olid_pkg::PosW'(pos_q);
      olen_q <= olid_pkg::PosW'(cnt_q);
    end
  end

  assign in_ready_o   = (state_q == olid_pkg::S_IDLE);
  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_pos_o    = opos_q;
  assign out_len_o    = olen_q;

endmodule

FILE: src/ordered_list_insert_delete_by_value.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_by_value
// Ordered list of up to DEPTH signed 32-bit values with insert at head,
// insert at tail and delete of the first matching value.
// ----------------------------------------------------------------------------
//  channel   dir  payload (lsb first)
//  s_axis    in   opcode[1:0], item_value[33:2]
//  m_axis    out  status[1:0], deleted_position[6:2], list_length[11:7]
//
//  Insert at tail, full insert or unused opcode: result without a memory walk.
//  Insert at head: moves each entry one place back, one entry per cycle.
//  Delete: search up to the match, then gap close from there, both through
//  the single read port of the entry memory.
//  Reset clears length and control state only; entries are undefined until written.
//  s_axis_tready is low from acceptance until the result is registered;
//  a stalled result holds in the output register.
module ordered_list_insert_delete_by_value #(
  parameter int unsigned DEPTH = olid_pkg::DepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [olid_pkg::InTdataW-1:0]   s_axis_tdata,  // opcode, item_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [olid_pkg::OutTdataW-1:0]  m_axis_tdata   // status, deleted_position,
                                                         // list_length
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                       re, we;
  logic [AW-1:0]              raddr, waddr;
  logic [olid_pkg::ValW-1:0]  wdata, rdata;
  logic [olid_pkg::StW-1:0]   status;
  logic [olid_pkg::PosW-1:0]  del_pos, list_len;

  olid_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_opcode_i  (s_axis_tdata[1:0]),
    .in_value_i   (s_axis_tdata[33:2]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_pos_o    (del_pos),
    .out_len_o    (list_len),
    .re_o         (re),
    .raddr_o      (raddr),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rdata_i      (rdata)
  );

  olid_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign m_axis_tdata = {4'b0000, list_len, del_pos, status};

endmodule

FILE: src/olid_checker.sv
// ----------------------------------------------------------------------------
// olid_checker
// Port-level checks on the ordered value list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olid_checker #(
  parameter int unsigned DEPTH = olid_pkg::DepthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [olid_pkg::OutTdataW-1:0] m_axis_tdata
);

  localparam logic [olid_pkg::PosW-1:0] FullLen = olid_pkg::PosW'(DEPTH);

  logic [olid_pkg::StW-1:0]  st;
  logic [olid_pkg::PosW-1:0] pos;
  logic [olid_pkg::PosW-1:0] len;
  logic                      in_beat;

  assign st      = m_axis_tdata[1:0];
  assign pos     = m_axis_tdata[6:2];
  assign len     = m_axis_tdata[11:7];
  assign in_beat = s_axis_tvalid && s_axis_tready;

  `CHK_ASSERT_RST(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `CHK_ASSERT_RST(a_busy_after_beat, clk_i, rst_ni, in_beat |=> !s_axis_tready)
  `CHK_ASSERT_RST(a_pos_only_ok, clk_i, rst_ni,
    m_axis_tvalid && pos != '0 |-> st == olid_pkg::ST_OK)
  `CHK_ASSERT_RST(a_full_len, clk_i, rst_ni,
    m_axis_tvalid && st == olid_pkg::ST_FULL |-> len == FullLen && pos == '0)

endmodule

bind ordered_list_insert_delete_by_value olid_checker #(.DEPTH(DEPTH)) u_olid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered value list: a queue-fed stream driver,
// a shadow list that predicts status, deleted position and length per beat,
// and a monitor that checks each result beat in order under random stalls.
// ----------------------------------------------------------------------------
module tb;
  import olid_pkg::*;

  localparam int unsigned ListDepth = DepthDef;
  localparam logic [OpW-1:0] OpNone = 2'd3;  // unused opcode, no operation
  localparam int HalfPeriod = 10;
  localparam int CycleLimit = 400000;
  localparam int IdlePct = 21;
  localparam int QuietStart = 3000;
  localparam int QuietEnd = 9000;
  localparam int TailCycles = 80;
  localparam int ChunkItems = 50;
  localparam int NumChunks = 11;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [ValW-1:0] value;
  } list_op_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] len;
  } list_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;

  list_op_t        op_queue[$];
  list_result_t    result_queue[$];
  logic [ValW-1:0] shadow_list[$];
  int              cycle_cnt;
  int              mismatch_cnt;

  ordered_list_insert_delete_by_value #(
    .DEPTH(ListDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // no idling at all inside the quiet window
  function automatic int idle_pct_now();
    return (cycle_cnt >= QuietStart && cycle_cnt < QuietEnd) ? 0 : IdlePct;
  endfunction

  // shadow list update for one accepted beat
  function automatic list_result_t apply_list_op(logic [OpW-1:0] op, logic [ValW-1:0] val);
    list_result_t r;
    int           hit;
    r.status = ST_OK;
    r.pos    = '0;
    hit      = -1;
    case (op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (shadow_list.size() >= ListDepth) begin
          r.status = ST_FULL;
        end else if (op == OP_INS_HEAD) begin
          shadow_list.push_front(val);
        end else begin
          shadow_list.push_back(val);
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          shadow_list.delete(hit);
          r.pos = PosW'(hit + 1);
        end
      end
      default: ;
    endcase
    r.len = PosW'(shadow_list.size());
    return r;
  endfunction

  task automatic check_result(logic [OutTdataW-1:0] beat);
    list_result_t want;
    status_e      got_st;
    logic [PosW-1:0] got_pos;
    logic [PosW-1:0] got_len;
    got_st  = status_e'(beat[1:0]);
    got_pos = beat[6:2];
    got_len = beat[11:7];
    if (result_queue.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected result beat at cycle %0d: status %0d pos %0d len %0d",
                 cycle_cnt, got_st, got_pos, got_len);
    end else begin
      want = result_queue.pop_front();
      if (got_st !== want.status || got_pos !== want.pos || got_len !== want.len) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch at cycle %0d: exp status %0d pos %0d len %0d, got %0d %0d %0d",
                   cycle_cnt, want.status, want.pos, want.len, got_st, got_pos, got_len);
      end
    end
  endtask

  // driver: predicts on acceptance, then offers the next pending beat
  always @(posedge clk_i or negedge rst_ni) begin : drive_ops
    list_op_t            item;
    logic [InTdataW-1:0] beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        result_queue.push_back(apply_list_op(s_axis_tdata[1:0], s_axis_tdata[33:2]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct_now()) begin
          item       = op_queue.pop_front();
          beat       = '0;
          beat[1:0]  = item.op;
          beat[33:2] = item.value;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct_now());
    end
  end

  task automatic push_op(logic [OpW-1:0] op, logic [ValW-1:0] val);
    list_op_t item;
    item.op    = op;
    item.value = val;
    op_queue.push_back(item);
  endtask

  // small pool so deletes hit and duplicates show up; full random otherwise
  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] pool[8];
    pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_002A, 32'h5555_5555};
    if ($urandom_range(0, 99) < 65) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic wait_drained();
    while (op_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int ins_pct[NumChunks];
    int roll;
    ins_pct      = '{85, 85, 20, 50, 90, 10, 50, 50, 70, 30, 50};
    cycle_cnt    = 0;
    mismatch_cnt = 0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list cases, extremes, duplicates, fill to full
    push_op(OP_DELETE, 32'h0000_0000);
    push_op(OpNone, 32'hFFFF_FFFF);
    push_op(OP_INS_HEAD, 32'h7FFF_FFFF);
    push_op(OP_INS_TAIL, 32'h8000_0000);
    push_op(OP_INS_HEAD, 32'h0000_0000);
    push_op(OP_INS_TAIL, 32'hFFFF_FFFF);
    push_op(OP_INS_TAIL, 32'h7FFF_FFFF);
    push_op(OP_DELETE, 32'h7FFF_FFFF);
    push_op(OP_DELETE, 32'hFFFF_FFFF);
    push_op(OP_DELETE, 32'h0001_2345);
    push_op(OpNone, 32'h0000_0000);
    for (int i = 0; i < 13; i++)
      push_op((i % 2) ? OP_INS_TAIL : OP_INS_HEAD, ValW'(i));
    push_op(OP_INS_HEAD, 32'hAAAA_AAAA);
    push_op(OP_INS_TAIL, 32'h5555_5555);
    wait_drained();

    for (int c = 0; c < NumChunks; c++) begin
      for (int n = 0; n < ChunkItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          push_op(OpNone, $urandom);
        else if (roll < 4 + ins_pct[c] * 96 / 100)
          push_op($urandom_range(0, 1) ? OP_INS_TAIL : OP_INS_HEAD, pick_value());
        else
          push_op(OP_DELETE, pick_value());
      end
      // sender holds off until every result is back
      if (c == 2 || c == 6) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && result_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

endmodule
